// ===== design/rmq_pkg.sv =====
// Shared types and constants for the rotation-matrix-to-quaternion unit.
package rmq_pkg;

  localparam int unsigned CompW = 16;

  typedef enum logic [1:0] {
    BR_TRACE = 2'd0,
    BR_ROW0  = 2'd1,
    BR_ROW1  = 2'd2,
    BR_ROW2  = 2'd3
  } branch_t;

  typedef struct packed {
    logic signed [CompW-1:0] first_col_x;
    logic signed [CompW-1:0] first_col_y;
    logic signed [CompW-1:0] first_col_z;
    logic signed [CompW-1:0] second_col_x;
    logic signed [CompW-1:0] second_col_y;
    logic signed [CompW-1:0] second_col_z;
    logic signed [CompW-1:0] third_col_x;
    logic signed [CompW-1:0] third_col_y;
    logic signed [CompW-1:0] third_col_z;
  } matrix_t;

  typedef struct packed {
    logic signed [CompW-1:0] quat_w;
    logic signed [CompW-1:0] quat_x;
    logic signed [CompW-1:0] quat_y;
    logic signed [CompW-1:0] quat_z;
    logic [1:0]              branch_used;
    logic                    status;
  } quat_t;

endpackage

// ===== design/rotation_matrix_to_quaternion_unit.sv =====
// Top level: select stage, square-root pipeline, three dividers, output register.
//
//   channel  ports                       transfer when
//   input    start, busy, matrix         start && !busy
//   result   done, quat                  done (one cycle, no backpressure)
//
// Fully pipelined: one matrix per cycle, busy is always low after reset.
// Registers in order: select, the bit-per-stage root pipe and its rounding register,
// the bit-per-stage dividers and their saturation register, then the output stage;
// 17 root stages and 33 divider stages at the default FRAC_BITS.
// Synchronous reset clears only the valid chain; nothing ever stalls.
module rotation_matrix_to_quaternion_unit #(
  parameter int FRAC_BITS = 14
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  output logic             busy,
  input  rmq_pkg::matrix_t matrix,
  output logic             done,
  output rmq_pkg::quat_t   quat
);

  // operand holds 1.0 plus up to three full-scale entries, with sign
  localparam int OpW   = ((FRAC_BITS > 18) ? FRAC_BITS : 18) + 2;
  localparam int RadW  = OpW + FRAC_BITS + ((OpW + FRAC_BITS) % 2);
  localparam int RootW = RadW / 2;
  localparam int SideW = 2 + 3 * 18;

  logic                  s1_valid;
  logic [1:0]            s1_branch;
  logic signed [OpW-1:0] s1_operand;
  logic signed [17:0]    s1_n0, s1_n1, s1_n2;

  assign busy = 1'b0;

  rmq_select #(.FRAC_BITS(FRAC_BITS), .OpW(OpW)) u_select (
    .clk, .rst, .in_valid(start && !busy), .m(matrix),
    .out_valid(s1_valid), .branch(s1_branch), .operand(s1_operand),
    .num0(s1_n0), .num1(s1_n1), .num2(s1_n2)
  );

  // operand is at least 1.0 by branch choice; clamp negatives for safety
  logic [OpW-1:0] op_pos;
  assign op_pos = s1_operand[OpW-1] ? '0 : s1_operand;

  logic             s2_valid;
  logic [RootW:0]   s2_root;
  logic [SideW-1:0] s2_side;

  rmq_sqrt #(.FRAC_BITS(FRAC_BITS), .OpW(OpW), .SideW(SideW)) u_sqrt (
    .clk, .rst, .in_valid(s1_valid), .operand(op_pos),
    .side_in({s1_branch, s1_n0, s1_n1, s1_n2}),
    .out_valid(s2_valid), .root(s2_root), .side_out(s2_side)
  );

  logic [1:0] s2_branch;
  logic signed [17:0] s2_n0, s2_n1, s2_n2;
  logic [RootW:0] safe_root;
  assign {s2_branch, s2_n0, s2_n1, s2_n2} = s2_side;
  assign safe_root = (s2_root == '0) ? (RootW+1)'(1) : s2_root;

  localparam int DSideW = 2 + 1 + 16;
  logic [RootW:0] half_full;
  logic [15:0]    half;
  assign half_full = (s2_root + 1'b1) >> 1;
  assign half = (half_full > (RootW+1)'(32767)) ? 16'h7FFF : half_full[15:0];

  logic d_valid0, d_valid1, d_valid2;
  logic signed [15:0] q0, q1, q2;
  logic [DSideW-1:0] d_side, d_side1, d_side2;

  rmq_divide #(.FRAC_BITS(FRAC_BITS), .RootW(RootW), .SideW(DSideW)) u_div0 (
    .clk, .rst, .in_valid(s2_valid), .num(s2_n0), .root(safe_root),
    .side_in({s2_branch, (s2_root == '0), half}),
    .out_valid(d_valid0), .quot(q0), .side_out(d_side)
  );
  rmq_divide #(.FRAC_BITS(FRAC_BITS), .RootW(RootW), .SideW(DSideW)) u_div1 (
    .clk, .rst, .in_valid(s2_valid), .num(s2_n1), .root(safe_root),
    .side_in('0), .out_valid(d_valid1), .quot(q1), .side_out(d_side1)
  );
  rmq_divide #(.FRAC_BITS(FRAC_BITS), .RootW(RootW), .SideW(DSideW)) u_div2 (
    .clk, .rst, .in_valid(s2_valid), .num(s2_n2), .root(safe_root),
    .side_in('0), .out_valid(d_valid2), .quot(q2), .side_out(d_side2)
  );

  logic [1:0]  f_branch;
  logic        f_zero;
  logic [15:0] f_half;
  rmq_pkg::quat_t quat_next;
  assign {f_branch, f_zero, f_half} = d_side;

  always_comb begin
    quat_next.branch_used = f_branch;
    quat_next.status      = f_zero;
    case (f_branch)
      rmq_pkg::BR_TRACE: begin
        quat_next.quat_w = f_half; quat_next.quat_x = q0;
        quat_next.quat_y = q1;     quat_next.quat_z = q2;
      end
      rmq_pkg::BR_ROW0: begin
        quat_next.quat_w = q0;     quat_next.quat_x = f_half;
        quat_next.quat_y = q1;     quat_next.quat_z = q2;
      end
      rmq_pkg::BR_ROW1: begin
        quat_next.quat_w = q0;     quat_next.quat_x = q1;
        quat_next.quat_y = f_half; quat_next.quat_z = q2;
      end
      default: begin
        quat_next.quat_w = q0;     quat_next.quat_x = q1;
        quat_next.quat_y = q2;     quat_next.quat_z = f_half;
      end
    endcase
    if (f_zero) begin
      quat_next.quat_w = '0; quat_next.quat_x = '0;
      quat_next.quat_y = '0; quat_next.quat_z = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= d_valid0 && d_valid1 && d_valid2 && (d_side1 == d_side2);
    end
    quat <= quat_next;
  end

endmodule

// ===== design/rmq_select.sv =====
// Stage 1: trace, branch choice, root operand and the three numerators.
module rmq_select #(
  parameter int FRAC_BITS = 14,
  parameter int OpW       = 20
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  input  rmq_pkg::matrix_t     m,
  output logic                 out_valid,
  output logic [1:0]           branch,
  output logic signed [OpW-1:0] operand,
  output logic signed [17:0]   num0,
  output logic signed [17:0]   num1,
  output logic signed [17:0]   num2
);

  logic signed [OpW-1:0] m00, m10, m20, m01, m11, m21, m02, m12, m22, trace, one;
  logic [1:0] br_c;
  logic signed [OpW-1:0] op_c, n0_c, n1_c, n2_c;

  always_comb begin
    m00 = OpW'(m.first_col_x);  m10 = OpW'(m.first_col_y);  m20 = OpW'(m.first_col_z);
    m01 = OpW'(m.second_col_x); m11 = OpW'(m.second_col_y); m21 = OpW'(m.second_col_z);
    m02 = OpW'(m.third_col_x);  m12 = OpW'(m.third_col_y);  m22 = OpW'(m.third_col_z);
    one = '0;
    one[FRAC_BITS] = 1'b1;
    trace = m00 + m11 + m22;
    if (trace > 0) begin
      br_c = rmq_pkg::BR_TRACE;
      op_c = trace + one;
      n0_c = m21 - m12; n1_c = m02 - m20; n2_c = m10 - m01;
    end else if (m00 > m11 && m00 > m22) begin
      br_c = rmq_pkg::BR_ROW0;
      op_c = one + m00 - m11 - m22;
      n0_c = m21 - m12; n1_c = m01 + m10; n2_c = m02 + m20;
    end else if (m11 > m22) begin
      br_c = rmq_pkg::BR_ROW1;
      op_c = one + m11 - m00 - m22;
      n0_c = m02 - m20; n1_c = m01 + m10; n2_c = m12 + m21;
    end else begin
      br_c = rmq_pkg::BR_ROW2;
      op_c = one + m22 - m00 - m11;
      n0_c = m10 - m01; n1_c = m02 + m20; n2_c = m12 + m21;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= in_valid;
    end
    branch  <= br_c;
    operand <= op_c;
    num0    <= n0_c[17:0];
    num1    <= n1_c[17:0];
    num2    <= n2_c[17:0];
  end

endmodule

// ===== design/rmq_sqrt.sv =====
// Pipelined integer square root, one result bit per stage, rounded to nearest.
module rmq_sqrt #(
  parameter int FRAC_BITS = 14,
  parameter int OpW       = 20,
  parameter int SideW     = 57
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             in_valid,
  input  logic [OpW-1:0]                   operand,
  input  logic [SideW-1:0]                 side_in,
  output logic                             out_valid,
  output logic [(OpW + FRAC_BITS + 1) / 2:0] root,
  output logic [SideW-1:0]                 side_out
);

  localparam int RadW  = OpW + FRAC_BITS + ((OpW + FRAC_BITS) % 2);
  localparam int Steps = RadW / 2;
  localparam int RootW = Steps;

  logic             vld  [Steps+1];
  logic [RadW-1:0]  rad  [Steps+1];
  logic [RootW-1:0] rt   [Steps+1];
  logic [RootW+1:0] rem  [Steps+1];
  logic [SideW-1:0] side [Steps+1];

  always_comb begin
    vld[0]  = in_valid;
    rad[0]  = RadW'(operand) << FRAC_BITS;
    rt[0]   = '0;
    rem[0]  = '0;
    side[0] = side_in;
  end

  for (genvar s = 0; s < Steps; s++) begin : g_step
    logic [RootW+1:0] trial, rem_sh;
    always_comb begin
      rem_sh = {rem[s][RootW-1:0], rad[s][RadW-1 -: 2]};
      trial  = {rt[s], 2'b01};
    end
    always_ff @(posedge clk) begin
      if (rst) begin
        vld[s+1] <= 1'b0;
      end else begin
        vld[s+1] <= vld[s];
      end
      rad[s+1]  <= rad[s] << 2;
      side[s+1] <= side[s];
      if (rem_sh >= trial) begin
        rem[s+1] <= rem_sh - trial;
        rt[s+1]  <= {rt[s][RootW-2:0], 1'b1};
      end else begin
        rem[s+1] <= rem_sh;
        rt[s+1]  <= {rt[s][RootW-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= vld[Steps];
    end
    side_out <= side[Steps];
    root     <= (rem[Steps] > (RootW+2)'(rt[Steps])) ? (RootW+1)'(rt[Steps]) + 1'b1
                                                     : (RootW+1)'(rt[Steps]);
  end

endmodule

// ===== design/rmq_divide.sv =====
// Pipelined restoring divider: (|num| << FRAC_BITS + r) / (2r), sign reapplied, saturated.
module rmq_divide #(
  parameter int FRAC_BITS = 14,
  parameter int RootW     = 17,
  parameter int SideW     = 8
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    in_valid,
  input  logic signed [17:0]      num,
  input  logic [RootW:0]          root,
  input  logic [SideW-1:0]        side_in,
  output logic                    out_valid,
  output logic signed [15:0]      quot,
  output logic [SideW-1:0]        side_out
);

  localparam int DvdW = 18 + FRAC_BITS + 1;
  localparam int DvsW = RootW + 2;

  logic             vld  [DvdW+1];
  logic [DvdW-1:0]  dvd  [DvdW+1];
  logic [DvsW-1:0]  dvs  [DvdW+1];
  logic [DvsW:0]    rem  [DvdW+1];
  logic             neg  [DvdW+1];
  logic [SideW-1:0] side [DvdW+1];

  logic [17:0] mag;
  always_comb begin
    mag     = num[17] ? 18'(-num) : 18'(num);
    vld[0]  = in_valid;
    dvd[0]  = (DvdW'(mag) << FRAC_BITS) + DvdW'(root);
    dvs[0]  = DvsW'(root) << 1;
    rem[0]  = '0;
    neg[0]  = num[17];
    side[0] = side_in;
  end

  // quotient bits shift into the dividend register as it empties
  for (genvar s = 0; s < DvdW; s++) begin : g_step
    logic [DvsW:0] sh;
    always_comb sh = {rem[s][DvsW-1:0], dvd[s][DvdW-1]};
    always_ff @(posedge clk) begin
      if (rst) begin
        vld[s+1] <= 1'b0;
      end else begin
        vld[s+1] <= vld[s];
      end
      dvs[s+1]  <= dvs[s];
      neg[s+1]  <= neg[s];
      side[s+1] <= side[s];
      if (sh >= (DvsW+1)'(dvs[s])) begin
        rem[s+1] <= sh - (DvsW+1)'(dvs[s]);
        dvd[s+1] <= {dvd[s][DvdW-2:0], 1'b1};
      end else begin
        rem[s+1] <= sh;
        dvd[s+1] <= {dvd[s][DvdW-2:0], 1'b0};
      end
    end
  end

  logic [DvdW-1:0] q;
  logic [15:0]     sat;
  always_comb begin
    q = dvd[DvdW];
    if (neg[DvdW]) begin
      sat = (q > DvdW'(32768)) ? 16'h8000 : 16'(-q);
    end else begin
      sat = (q > DvdW'(32767)) ? 16'h7FFF : q[15:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= vld[DvdW];
    end
    quot     <= sat;
    side_out <= side[DvdW];
  end

endmodule

// ===== design/rmq_checker.sv =====
// Port-level checks for the quaternion unit, bound to the top level.
module rmq_checker (
  input logic           clk,
  input logic           rst,
  input logic           busy,
  input logic           done,
  input rmq_pkg::quat_t quat
);

  a_no_busy: assert property (@(posedge clk) disable iff (rst) !busy)
    else $error("busy raised in a pipeline that never stalls");

  a_done_after_reset: assert property (@(posedge clk) disable iff (rst)
      $past(rst) |-> !done)
    else $error("result strobe right after reset");

  a_zero_status: assert property (@(posedge clk) disable iff (rst)
      done && quat.status |-> quat.quat_w == 0 && quat.quat_x == 0 &&
      quat.quat_y == 0 && quat.quat_z == 0)
    else $error("zero-divisor result with nonzero components");

  a_status_never: assert property (@(posedge clk) disable iff (rst)
      done |-> !quat.status)
    else $error("zero divisor flagged though operand is at least one");

endmodule

bind rotation_matrix_to_quaternion_unit rmq_checker u_rmq_checker (
  .clk, .rst, .busy, .done, .quat
);
